[src/drhp_pkg.sv]
`default_nettype none
package drhp_pkg;

  // Largest column index the design tracks before saturating
  localparam int unsigned MAX_COLUMNS  = 2048;
  localparam int unsigned COL_FIELD_MX = 2047;
  localparam int unsigned COL_LIMIT    =
    ((MAX_COLUMNS - 1) > COL_FIELD_MX) ? COL_FIELD_MX : (MAX_COLUMNS - 1);

  localparam int unsigned VARINT_LONG  = 8;  // bytes carrying seven bits each
  localparam logic [63:0] TYPE_BLOB_MIN = 64'd12;
  localparam logic [63:0] TYPE_FIX_MAX  = 64'd9;

  // Parse phase, one-hot
  typedef enum logic [3:0] {
    PH_PAYLEN  = 4'b0001,
    PH_ROWID   = 4'b0010,
    PH_HDRLEN  = 4'b0100,
    PH_COLTYPE = 4'b1000
  } phase_e;

  // Field kind codes on the result channel
  localparam logic [1:0] KIND_PAYLEN  = 2'd0;
  localparam logic [1:0] KIND_ROWID   = 2'd1;
  localparam logic [1:0] KIND_HDRLEN  = 2'd2;
  localparam logic [1:0] KIND_COLTYPE = 2'd3;

  // Content size of serial types 0 to 9
  function automatic logic [62:0] fixed_size(input logic [3:0] t);
    logic [62:0] s;
    s = '0;
    case (t)
      4'd1:    s = 63'd1;
      4'd2:    s = 63'd2;
      4'd3:    s = 63'd3;
      4'd4:    s = 63'd4;
      4'd5:    s = 63'd6;
      4'd6:    s = 63'd8;
      4'd7:    s = 63'd8;
      default: s = '0;
    endcase
    return s;
  endfunction

endpackage
`default_nettype wire

[src/drhp_if.sv]
`default_nettype none
interface drhp_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       cell_start;

  modport source (output valid, output data_byte, output cell_start, input ready);
  modport sink   (input valid, input data_byte, input cell_start, output ready);
endinterface

interface drhp_out_if;
  logic        valid;
  logic        ready;
  logic [1:0]  field_kind;
  logic [63:0] decoded_value;
  logic [62:0] content_size;
  logic [10:0] column_number;
  logic        reserved_type;
  logic        header_overrun;
  logic        last_column;

  modport source (output valid, output field_kind, output decoded_value,
                  output content_size, output column_number, output reserved_type,
                  output header_overrun, output last_column, input ready);
  modport sink   (input valid, input field_kind, input decoded_value,
                  input content_size, input column_number, input reserved_type,
                  input header_overrun, input last_column, output ready);
endinterface
`default_nettype wire

[src/db_record_header_parser_core.sv]
`default_nettype none
// Record header varint parser for table-leaf cells.
// in_i takes one cell byte per item; cell_start marks the first byte of a cell
// and restarts the parser. out_o gives one item per varint that completes or runs past
// the header end: payload length, row id, header length, then one serial type per
// column with its content size, column index and reserved, overrun and last-column
// flags. Bytes arriving while no cell is open give no item.
// Throughput: one byte per cycle while out_o is not stalled. The varint accumulator
// and the header byte counter are updated combinationally from the input register,
// so the parse loop closes every clock.
// Path: the last byte of a varint is captured in the input register, then the
// result register loads from it and presents the result on out_o.
// Reset: no cell is open and both registers are empty; the first byte with
// cell_start begins parsing.
// Stall: while out_o is stalled with a result pending, the result holds, the
// parser does not advance, the waiting byte stays in the input register and
// in_i drops ready until the result is taken.
module db_record_header_parser_core (
  input  wire            clk_i,
  input  wire            rst_ni,
  drhp_in_if.sink        in_i,
  drhp_out_if.source     out_o
);

  // Input register
  logic       in_vld_q;
  logic [7:0] in_byte_q;
  logic       in_start_q;

  // Parser state
  logic [63:0]          acc_q, acc_d;
  logic [3:0]           nbytes_q, nbytes_d;
  drhp_pkg::phase_e     phase_q, phase_d;
  logic [63:0]          hleft_q, hleft_d;
  logic [10:0]          col_q, col_d;
  logic                 done_q, done_d;

  // Result register
  logic        out_vld_q;
  logic [1:0]  kind_q, kind_d;
  logic [63:0] val_q, val_d;
  logic [62:0] size_q, size_d;
  logic [10:0] colnum_q, colnum_d;
  logic        rsv_q, rsv_d;
  logic        ovr_q, ovr_d;
  logic        last_q, last_d;
  logic        emit;

  logic advance;

  assign advance    = in_vld_q && (!out_vld_q || out_o.ready);
  assign in_i.ready = !in_vld_q || advance;

  // Capture the next byte
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q <= 1'b0;
    end else if (in_i.ready) begin
      in_vld_q <= in_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_i.ready && in_i.valid) begin
      in_byte_q  <= in_i.data_byte;
      in_start_q <= in_i.cell_start;
    end
  end

  // Decode one byte
  always_comb begin
    logic [63:0]      acc;
    logic [3:0]       nb;
    drhp_pkg::phase_e ph;
    logic [63:0]      hl;
    logic [10:0]      col;
    logic             dn;
    logic             complete;
    logic [63:0]      tmin;

    acc = acc_q;
    nb  = nbytes_q;
    ph  = phase_q;
    hl  = hleft_q;
    col = col_q;
    dn  = done_q;
    complete = 1'b0;
    tmin = '0;

    emit   = 1'b0;
    kind_d = drhp_pkg::KIND_PAYLEN;
    val_d  = '0;
    size_d = '0;
    colnum_d = '0;
    rsv_d  = 1'b0;
    ovr_d  = 1'b0;
    last_d = 1'b0;

    // Restart on cell start
    if (in_start_q) begin
      acc = '0;
      nb  = '0;
      ph  = drhp_pkg::PH_PAYLEN;
      hl  = '0;
      col = '0;
      dn  = 1'b0;
    end

    if (!dn) begin
      // Shift the byte into the accumulator
      if (nb < 4'(drhp_pkg::VARINT_LONG)) begin
        acc = {acc[56:0], in_byte_q[6:0]};
        complete = !in_byte_q[7];
      end else begin
        acc = {acc[55:0], in_byte_q};
        complete = 1'b1;
      end
      nb = nb + 4'd1;

      // Count down the header bytes
      if (ph == drhp_pkg::PH_COLTYPE && hl != '0) begin
        hl = hl - 64'd1;
      end

      if (ph == drhp_pkg::PH_COLTYPE && !complete && hl == '0) begin
        // Varint runs past header end
        emit     = 1'b1;
        kind_d   = drhp_pkg::KIND_COLTYPE;
        val_d    = acc;
        colnum_d = col;
        ovr_d    = 1'b1;
        acc = '0;
        nb  = '0;
        dn  = 1'b1;
      end else if (complete) begin
        emit  = 1'b1;
        val_d = acc;
        case (ph)
          drhp_pkg::PH_PAYLEN: begin
            kind_d = drhp_pkg::KIND_PAYLEN;
            ph     = drhp_pkg::PH_ROWID;
          end
          drhp_pkg::PH_ROWID: begin
            kind_d = drhp_pkg::KIND_ROWID;
            ph     = drhp_pkg::PH_HDRLEN;
          end
          drhp_pkg::PH_HDRLEN: begin
            kind_d = drhp_pkg::KIND_HDRLEN;
            if (acc < {60'd0, nb}) begin
              ovr_d = 1'b1;
              dn    = 1'b1;
            end else begin
              hl = acc - {60'd0, nb};
              if (hl == '0) begin
                dn = 1'b1;
              end else begin
                ph = drhp_pkg::PH_COLTYPE;
              end
            end
          end
          default: begin
            kind_d   = drhp_pkg::KIND_COLTYPE;
            colnum_d = col;
            last_d   = (hl == '0);
            tmin     = acc - drhp_pkg::TYPE_BLOB_MIN;
            if (acc <= drhp_pkg::TYPE_FIX_MAX) begin
              size_d = drhp_pkg::fixed_size(acc[3:0]);
            end else if (acc < drhp_pkg::TYPE_BLOB_MIN) begin
              rsv_d = 1'b1;
            end else begin
              // Blob and text sizes share the halved offset
              size_d = tmin[63:1];
            end
            if (col < 11'(drhp_pkg::COL_LIMIT)) begin
              col = col + 11'd1;
            end
            if (hl == '0) begin
              dn = 1'b1;
            end
          end
        endcase
        acc = '0;
        nb  = '0;
      end
    end

    acc_d    = acc;
    nbytes_d = nb;
    phase_d  = ph;
    hleft_d  = hl;
    col_d    = col;
    done_d   = dn;
  end

  // Advance parser state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      acc_q    <= '0;
      nbytes_q <= '0;
      phase_q  <= drhp_pkg::PH_PAYLEN;
      hleft_q  <= '0;
      col_q    <= '0;
      done_q   <= 1'b1;
    end else if (advance) begin
      acc_q    <= acc_d;
      nbytes_q <= nbytes_d;
      phase_q  <= phase_d;
      hleft_q  <= hleft_d;
      col_q    <= col_d;
      done_q   <= done_d;
    end
  end

  // Hold the result until taken
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (advance) begin
      out_vld_q <= emit;
    end else if (out_o.ready) begin
      out_vld_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance && emit) begin
      kind_q   <= kind_d;
      val_q    <= val_d;
      size_q   <= size_d;
      colnum_q <= colnum_d;
      rsv_q    <= rsv_d;
      ovr_q    <= ovr_d;
      last_q   <= last_d;
    end
  end

  assign out_o.valid          = out_vld_q;
  assign out_o.field_kind     = kind_q;
  assign out_o.decoded_value  = val_q;
  assign out_o.content_size   = size_q;
  assign out_o.column_number  = colnum_q;
  assign out_o.reserved_type  = rsv_q;
  assign out_o.header_overrun = ovr_q;
  assign out_o.last_column    = last_q;

endmodule
`default_nettype wire

[sim/tb_top.sv]
`timescale 1ns / 100ps
module tb_top;

  localparam int unsigned CYCLE_LIMIT = 600000;
  localparam int unsigned RANDOM_BYTES = 1320;
  localparam int unsigned LONG_TYPES = 300;

  // One decoded header field as it leaves the parser
  typedef struct packed {
    logic [1:0]  kind;
    logic [63:0] value;
    logic [62:0] size;
    logic [10:0] col;
    logic        rsv;
    logic        ovr;
    logic        last;
  } hdr_field_t;

  // One cell byte, optionally with a pinned expectation
  typedef struct packed {
    logic [7:0] data;
    logic       start;
    logic       pin;
    logic       has;
    hdr_field_t want;
  } byte_item_t;

  typedef enum int {
    CELL_OK,
    CELL_EMPTY,
    CELL_SHORT,
    CELL_CUT,
    CELL_ABORT,
    CELL_NOISE
  } cell_shape_e;

  logic clk;
  logic rst_n;

  drhp_in_if  byte_ch();
  drhp_out_if field_ch();

  db_record_header_parser_core dut (
    .clk_i  (clk),
    .rst_ni (rst_n),
    .in_i   (byte_ch),
    .out_o  (field_ch)
  );

  byte_item_t  byte_q[$];
  byte_item_t  dir_tab[$];
  hdr_field_t  field_q[$];
  int unsigned acc_idx;
  int unsigned shown_idx;
  int unsigned steady_from;
  int unsigned parsed_bytes;
  int unsigned mismatches;
  int unsigned cycles;

  // Parser shadow state
  logic [63:0]      acc;
  int unsigned      acc_len;
  drhp_pkg::phase_e phase;
  logic [63:0]      hdr_left;
  logic [10:0]      col_idx;
  bit               idle;

  // Decode one byte; returns 1 when it yields a field
  function automatic bit decode_byte(input logic [7:0] b, input bit s,
                                     output hdr_field_t f);
    bit          fin;
    logic [63:0] v;
    logic [63:0] sz;
    int unsigned n;
    f = '0;
    if (s) begin
      acc = '0;
      acc_len = 0;
      phase = drhp_pkg::PH_PAYLEN;
      hdr_left = '0;
      col_idx = '0;
      idle = 1'b0;
    end
    if (idle) return 1'b0;
    // First eight bytes give seven bits, the ninth gives eight
    if (acc_len < 8) begin
      acc = {acc[56:0], b[6:0]};
      fin = !b[7];
    end else begin
      acc = {acc[55:0], b};
      fin = 1'b1;
    end
    acc_len++;
    // Header bytes ran out inside a serial type
    if (phase == drhp_pkg::PH_COLTYPE) begin
      if (hdr_left != 0) hdr_left--;
      if (!fin && hdr_left == 0) begin
        f.kind = drhp_pkg::KIND_COLTYPE;
        f.value = acc;
        f.col = col_idx;
        f.ovr = 1'b1;
        acc = '0;
        acc_len = 0;
        idle = 1'b1;
        return 1'b1;
      end
    end
    if (!fin) return 1'b0;
    v = acc;
    n = acc_len;
    acc = '0;
    acc_len = 0;
    f.value = v;
    case (phase)
      drhp_pkg::PH_PAYLEN: begin
        f.kind = drhp_pkg::KIND_PAYLEN;
        phase = drhp_pkg::PH_ROWID;
      end
      drhp_pkg::PH_ROWID: begin
        f.kind = drhp_pkg::KIND_ROWID;
        phase = drhp_pkg::PH_HDRLEN;
      end
      drhp_pkg::PH_HDRLEN: begin
        f.kind = drhp_pkg::KIND_HDRLEN;
        if (v < 64'(n)) begin
          f.ovr = 1'b1;
          idle = 1'b1;
        end else begin
          hdr_left = v - 64'(n);
          if (hdr_left == 0) idle = 1'b1;
          else phase = drhp_pkg::PH_COLTYPE;
        end
      end
      default: begin
        f.kind = drhp_pkg::KIND_COLTYPE;
        f.col = col_idx;
        f.last = (hdr_left == 0);
        sz = '0;
        if (v < 10) begin
          case (v[3:0])
            4'd1, 4'd2, 4'd3, 4'd4: sz = v;
            4'd5:                   sz = 64'd6;
            4'd6, 4'd7:             sz = 64'd8;
            default:                sz = '0;
          endcase
        end else if (v < 12) begin
          f.rsv = 1'b1;
        end else begin
          sz = (v - (v[0] ? 64'd13 : 64'd12)) >> 1;
        end
        f.size = sz[62:0];
        if (col_idx < drhp_pkg::COL_LIMIT) col_idx++;
        if (f.last) idle = 1'b1;
      end
    endcase
    return 1'b1;
  endfunction

  function automatic hdr_field_t mk(input logic [1:0] k, input logic [63:0] v,
                                    input logic [62:0] sz, input logic [10:0] c,
                                    input bit r, input bit o, input bit l);
    hdr_field_t f;
    f = '{kind: k, value: v, size: sz, col: c, rsv: r, ovr: o, last: l};
    return f;
  endfunction

  function automatic byte_item_t row_free(input logic [7:0] d, input bit s);
    byte_item_t it;
    it = '0;
    it.data = d;
    it.start = s;
    return it;
  endfunction

  function automatic byte_item_t row_none(input logic [7:0] d, input bit s);
    byte_item_t it;
    it = row_free(d, s);
    it.pin = 1'b1;
    return it;
  endfunction

  function automatic byte_item_t row_want(input logic [7:0] d, input bit s,
                                          input hdr_field_t w);
    byte_item_t it;
    it = row_none(d, s);
    it.has = 1'b1;
    it.want = w;
    return it;
  endfunction

  task automatic push_item(input logic [7:0] d, input bit s, input bit counts);
    byte_q.insert(byte_q.size(), row_free(d, s));
    if (counts) parsed_bytes++;
  endtask

  // Encoded length; pad adds non-minimal leading groups, 9 forces the long form
  function automatic int varint_len(input logic [63:0] v, input int pad);
    int n;
    if (v[63:56] != 0 || pad >= 9) return 9;
    n = 1;
    while (n < 8 && (v >> (7 * n)) != 0) n++;
    n += pad;
    if (n > 8) n = 8;
    return n;
  endfunction

  task automatic put_varint(input logic [63:0] v, input int pad, input bit s,
                            input bit counts);
    int         n;
    logic [7:0] b;
    n = varint_len(v, pad);
    for (int i = 0; i < n; i++) begin
      if (n == 9) b = (i == 8) ? v[7:0] : {1'b1, 7'(v >> (8 + 7 * (7 - i)))};
      else b = {(i < n - 1), 7'(v >> (7 * (n - 1 - i)))};
      push_item(b, s && i == 0, counts);
    end
  endtask

  function automatic logic [63:0] rand_value();
    case ($urandom_range(0, 3))
      0:       return 64'($urandom_range(0, 127));
      1:       return 64'($urandom_range(0, 16383));
      2:       return {$urandom, $urandom} >> $urandom_range(0, 63);
      default: return {$urandom, $urandom};
    endcase
  endfunction

  function automatic logic [63:0] rand_type();
    case ($urandom_range(0, 9))
      0, 1, 2, 3, 4, 5: return 64'($urandom_range(0, 13));
      6:                return 64'($urandom_range(14, 127));
      7:                return 64'($urandom_range(128, 16383));
      8:                return rand_value();
      default:          return {$urandom, $urandom};
    endcase
  endfunction

  function automatic int rand_pad();
    case ($urandom_range(0, 15))
      0:       return 9;
      1, 2:    return $urandom_range(1, 3);
      default: return 0;
    endcase
  endfunction

  // Build one cell of the given shape
  task automatic put_cell(input cell_shape_e shape);
    logic [63:0] types[$];
    int          pads[$];
    int          ncol;
    int          tsum;
    int          cut;
    int          hpad;
    int          hl;
    int          v;
    if (shape == CELL_NOISE) begin
      repeat ($urandom_range(1, 4)) push_item(8'($urandom), 1'b0, 1'b0);
      return;
    end
    put_varint(rand_value(), rand_pad(), 1'b1, 1'b1);
    if (shape == CELL_ABORT) begin
      repeat ($urandom_range(1, 3)) push_item({1'b1, 7'($urandom)}, 1'b0, 1'b1);
      return;
    end
    put_varint(rand_value(), rand_pad(), 1'b0, 1'b1);
    if (shape == CELL_SHORT) begin
      v = $urandom_range(0, 2);
      put_varint(64'(v), v, 1'b0, 1'b1);
      repeat ($urandom_range(0, 3)) push_item(8'($urandom), 1'b0, 1'b0);
      return;
    end
    ncol = (shape == CELL_EMPTY) ? 0 : $urandom_range(1, 12);
    tsum = 0;
    cut = 0;
    for (int i = 0; i < ncol; i++) begin
      types.insert(types.size(), rand_type());
      pads.insert(pads.size(), ($urandom_range(0, 9) == 0) ? $urandom_range(1, 3) : 0);
      tsum += varint_len(types[i], pads[i]);
    end
    // Last serial type spans several bytes; header ends inside it
    if (shape == CELL_CUT) begin
      types.insert(types.size(), {$urandom, $urandom} | 64'h80);
      pads.insert(pads.size(), 0);
      tsum += varint_len(types[ncol], 0);
      cut = $urandom_range(1, varint_len(types[ncol], 0) - 1);
      ncol++;
    end
    hpad = ($urandom_range(0, 7) == 0) ? 1 : 0;
    hl = 1;
    while (hl < 9 && varint_len(64'(tsum + hl - cut), hpad) != hl) hl++;
    put_varint(64'(tsum + hl - cut), hpad, 1'b0, 1'b1);
    for (int i = 0; i < ncol; i++) put_varint(types[i], pads[i], 1'b0, 1'b1);
    // Column content follows the header and is ignored
    repeat ($urandom_range(0, 3)) push_item(8'($urandom), 1'b0, 1'b0);
  endtask

  // Clock
  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Byte source: hold an item until taken, idle in random bursts
  initial begin : drive_bytes
    int gap_left;
    gap_left = 0;
    byte_ch.valid <= 1'b0;
    byte_ch.data_byte <= '0;
    byte_ch.cell_start <= 1'b0;
    @(posedge rst_n);
    forever begin
      @(negedge clk);
      if (!(byte_ch.valid && shown_idx == acc_idx)) begin
        if (gap_left > 0) begin
          gap_left--;
          byte_ch.valid <= 1'b0;
        end else if (acc_idx < byte_q.size()) begin
          if (acc_idx < steady_from && $urandom_range(0, 5) == 0) begin
            gap_left = $urandom_range(0, 7);
            byte_ch.valid <= 1'b0;
          end else begin
            byte_ch.valid <= 1'b1;
            byte_ch.data_byte <= byte_q[acc_idx].data;
            byte_ch.cell_start <= byte_q[acc_idx].start;
            shown_idx = acc_idx;
          end
        end else begin
          byte_ch.valid <= 1'b0;
        end
      end
    end
  end

  // Result sink: stall in random bursts
  initial begin : drive_ready
    int stall_left;
    stall_left = 0;
    field_ch.ready <= 1'b0;
    @(posedge rst_n);
    forever begin
      @(negedge clk);
      if (stall_left > 0) begin
        stall_left--;
        field_ch.ready <= 1'b0;
      end else if (acc_idx < steady_from && $urandom_range(0, 5) == 0) begin
        stall_left = $urandom_range(0, 7);
        field_ch.ready <= 1'b0;
      end else begin
        field_ch.ready <= 1'b1;
      end
    end
  end

  // Predict on each accepted byte, check each accepted result
  always @(posedge clk) begin : watch
    hdr_field_t want;
    hdr_field_t got;
    bit         has;
    if (rst_n) begin
      cycles++;
      if (byte_ch.valid && byte_ch.ready) begin
        has = decode_byte(byte_q[acc_idx].data, byte_q[acc_idx].start, want);
        if (byte_q[acc_idx].pin) begin
          has = byte_q[acc_idx].has;
          want = byte_q[acc_idx].want;
        end
        if (has) field_q.insert(field_q.size(), want);
        acc_idx++;
      end
      if (field_ch.valid && field_ch.ready) begin
        got = {field_ch.field_kind, field_ch.decoded_value, field_ch.content_size,
               field_ch.column_number, field_ch.reserved_type,
               field_ch.header_overrun, field_ch.last_column};
        if (field_q.size() == 0) begin
          mismatches++;
          if (mismatches <= 10)
            $display("unexpected field: kind=%0d value=%h col=%0d", got.kind,
                     got.value, got.col);
        end else begin
          want = field_q.pop_front();
          if (got !== want) begin
            mismatches++;
            if (mismatches <= 10) begin
              $display("field mismatch: exp kind=%0d value=%h size=%h col=%0d r/o/l=%b%b%b",
                       want.kind, want.value, want.size, want.col, want.rsv,
                       want.ovr, want.last);
              $display("                got kind=%0d value=%h size=%h col=%0d r/o/l=%b%b%b",
                       got.kind, got.value, got.size, got.col, got.rsv,
                       got.ovr, got.last);
            end
          end
        end
      end
      if (cycles > CYCLE_LIMIT) begin
        $display("db_record_header_parser_core test failed");
        $finish;
      end
    end
  end

  initial begin
    acc = '0;
    acc_len = 0;
    phase = drhp_pkg::PH_PAYLEN;
    hdr_left = '0;
    col_idx = '0;
    idle = 1'b1;
    acc_idx = 0;
    shown_idx = 0;
    mismatches = 0;
    cycles = 0;
    parsed_bytes = 0;
    rst_n = 1'b0;

    // Directed cells: idle byte, all-ones row id, reserved and text/blob
    // types, header too short, empty record, type running past header end
    dir_tab = '{
      row_none(8'h55, 1'b0),
      row_want(8'h00, 1'b1, mk(drhp_pkg::KIND_PAYLEN, 64'd0, 63'd0, 11'd0, 0, 0, 0)),
      row_free(8'hFF, 1'b0), row_free(8'hFF, 1'b0), row_free(8'hFF, 1'b0),
      row_free(8'hFF, 1'b0), row_free(8'hFF, 1'b0), row_free(8'hFF, 1'b0),
      row_free(8'hFF, 1'b0), row_free(8'hFF, 1'b0),
      row_want(8'hFF, 1'b0,
               mk(drhp_pkg::KIND_ROWID, 64'hFFFF_FFFF_FFFF_FFFF, 63'd0, 11'd0, 0, 0, 0)),
      row_want(8'h06, 1'b0, mk(drhp_pkg::KIND_HDRLEN, 64'd6, 63'd0, 11'd0, 0, 0, 0)),
      row_want(8'h0A, 1'b0, mk(drhp_pkg::KIND_COLTYPE, 64'd10, 63'd0, 11'd0, 1, 0, 0)),
      row_free(8'h0B, 1'b0),
      row_free(8'h0C, 1'b0),
      row_free(8'h0D, 1'b0),
      row_want(8'h07, 1'b0, mk(drhp_pkg::KIND_COLTYPE, 64'd7, 63'd8, 11'd4, 0, 0, 1)),
      row_none(8'h33, 1'b0),
      row_free(8'h01, 1'b1),
      row_free(8'h02, 1'b0),
      row_want(8'h00, 1'b0, mk(drhp_pkg::KIND_HDRLEN, 64'd0, 63'd0, 11'd0, 0, 1, 0)),
      row_free(8'h7F, 1'b1),
      row_free(8'h00, 1'b0),
      row_want(8'h01, 1'b0, mk(drhp_pkg::KIND_HDRLEN, 64'd1, 63'd0, 11'd0, 0, 0, 0)),
      row_free(8'h00, 1'b1),
      row_free(8'h00, 1'b0),
      row_free(8'h02, 1'b0),
      row_want(8'h81, 1'b0, mk(drhp_pkg::KIND_COLTYPE, 64'd1, 63'd0, 11'd0, 0, 1, 0))
    };
    foreach (dir_tab[i]) byte_q.insert(byte_q.size(), dir_tab[i]);

    // Wide record: run the column index well past eight bits
    put_varint(64'd0, 0, 1'b1, 1'b1);
    put_varint(rand_value(), 0, 1'b0, 1'b1);
    put_varint(64'(LONG_TYPES + 2), 0, 1'b0, 1'b1);
    repeat (LONG_TYPES) push_item(8'($urandom_range(0, 127)), 1'b0, 1'b1);

    // Random cells, mostly well formed
    parsed_bytes = 0;
    while (parsed_bytes < RANDOM_BYTES) begin
      case ($urandom_range(0, 99)) inside
        [0:71]:  put_cell(CELL_OK);
        [72:77]: put_cell(CELL_EMPTY);
        [78:84]: put_cell(CELL_SHORT);
        [85:92]: put_cell(CELL_CUT);
        [93:96]: put_cell(CELL_ABORT);
        default: put_cell(CELL_NOISE);
      endcase
    end
    steady_from = byte_q.size() - 250;

    repeat (2) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // Drain: all bytes taken, all fields seen, then a short tail
    while (acc_idx < byte_q.size() || field_q.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    if (mismatches == 0) begin
      $display("db_record_header_parser_core test passed");
    end else begin
      $display("db_record_header_parser_core test failed");
    end
    $finish;
  end

endmodule

[files.f]
src/drhp_pkg.sv
src/drhp_if.sv
src/db_record_header_parser_core.sv
sim/tb_top.sv
